@@ rtl/arbe_pkg.sv @@
// ----------------------------------------------------------------------------
// arbe_pkg: shared definitions for the averaging report-by-exception channel
// Register indexes, millisecond scaling constants, field widths and the
// result group handed from the averaging unit to the top level.
// ----------------------------------------------------------------------------
package arbe_pkg;

  // Configuration register indexes, in the order of the register map.
  typedef enum logic [1:0] {
    REG_UPDATE_INTERVAL = 2'd0,
    REG_SEND_DELTA      = 2'd1,
    REG_SEND_MAX        = 2'd2,
    REG_SEND_MIN        = 2'd3
  } cfg_reg_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;

  // Scaling of register units into milliseconds and counts.
  localparam int MS_PER_TEN_S     = 10000;
  localparam int MS_PER_S         = 1000;
  localparam int COUNTS_PER_DELTA = 10;

  // Widths of the pre-scaled thresholds (largest register value times scale).
  localparam int WAIT_MS_W  = 22;  // 255 * 10000
  localparam int MAX_MS_W   = 26;  // 65535 * 1000
  localparam int DELTA_W    = 12;  // 255 * 10

  // Register reset values, already scaled.
  localparam logic [WAIT_MS_W-1:0] UPDATE_MS_RST = WAIT_MS_W'(30 * MS_PER_TEN_S);
  localparam logic [DELTA_W-1:0]   DELTA_RST     = DELTA_W'(10 * COUNTS_PER_DELTA);
  localparam logic [MAX_MS_W-1:0]  MAX_MS_RST    = MAX_MS_W'(600 * MS_PER_S);
  localparam logic [WAIT_MS_W-1:0] MIN_MS_RST    = WAIT_MS_W'(3 * MS_PER_TEN_S);

  // Default module parameters.
  localparam int SAMPLES_PER_AVERAGE_DEF = 3;
  localparam int SAMPLE_WAIT_TENS_DEF    = 1;

  // Result of the averaging unit for the sample taken in this cycle.
  typedef struct packed {
    logic                done;   // this sample completes a set
    logic [SAMPLE_W-1:0] mean;   // truncated mean of the set, valid with done
  } mean_t;

endpackage

@@ rtl/averaging_report_by_exception.sv @@
// An accepted poll enters the result register once that register is empty or being
// emptied, and is offered from then on, held there while the receiver stalls.
// Throughput: one poll per cycle while unstalled; a poll's decisions are combinational.
// Reset (synchronous, rst_n low): registers return to their defaults (30, 10, 600, 3),
// readings and timestamps clear, the sample wait is twice the sample interval
// and both pipeline stages empty.
// ----------------------------------------------------------------------------
// averaging_report_by_exception: send-on-delta channel with averaged readings
// Each input beat is one poll. The channel decides whether to offer its current
// averaged reading for sending, takes a raw sample when one is due, and folds
// every full set of samples into a new averaged reading.
// ----------------------------------------------------------------------------
module averaging_report_by_exception #(
  parameter int SAMPLES_PER_AVERAGE = arbe_pkg::SAMPLES_PER_AVERAGE_DEF,
  parameter int SAMPLE_WAIT_TENS    = arbe_pkg::SAMPLE_WAIT_TENS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Poll channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [55:0]                     in_tdata,   // now_ms, adc_sample, link_busy
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [39:0]                     out_tdata,  // send_now, sent_value, reading
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [arbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arbe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import arbe_pkg::*;

  localparam logic [WAIT_MS_W-1:0] WAIT_SHORT_MS = WAIT_MS_W'(SAMPLE_WAIT_TENS * MS_PER_TEN_S);
  localparam logic [WAIT_MS_W-1:0] WAIT_RST_MS   =
    WAIT_MS_W'(2 * SAMPLE_WAIT_TENS * MS_PER_TEN_S);

  // --------------------------------------------------------------------------
  // Configuration. The registers are kept already scaled to milliseconds or
  // counts, so the poll path only compares. A zero register stays zero after
  // scaling, which is what the disable tests look at.
  // --------------------------------------------------------------------------
  logic [WAIT_MS_W-1:0] update_ms_r;
  logic [DELTA_W-1:0]   delta_r;
  logic [MAX_MS_W-1:0]  max_ms_r;
  logic [WAIT_MS_W-1:0] min_ms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      update_ms_r <= UPDATE_MS_RST;
      delta_r     <= DELTA_RST;
      max_ms_r    <= MAX_MS_RST;
      min_ms_r    <= MIN_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_UPDATE_INTERVAL:
          update_ms_r <= WAIT_MS_W'(32'(cfg_data[7:0]) * 32'(MS_PER_TEN_S));
        REG_SEND_DELTA:
          delta_r     <= DELTA_W'(32'(cfg_data[7:0]) * 32'(COUNTS_PER_DELTA));
        REG_SEND_MAX:
          max_ms_r    <= MAX_MS_W'(32'(cfg_data) * 32'(MS_PER_S));
        REG_SEND_MIN:
          min_ms_r    <= WAIT_MS_W'(32'(cfg_data[7:0]) * 32'(MS_PER_TEN_S));
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. The input register takes a new beat whenever it is empty or
  // its poll moves on this cycle; the poll moves on whenever the result
  // register is empty or being emptied, so a waiting result blocks a new
  // beat only while the input register is also full.
  // --------------------------------------------------------------------------
  logic                s1_v_r;
  logic [TIME_W-1:0]   s1_now_r;
  logic [SAMPLE_W-1:0] s1_adc_r;
  logic                s1_busy_r;
  logic                out_v_r;
  logic                out_load;
  logic                s1_fire;
  logic                in_fire;

  assign out_load  = !out_v_r || out_tready;
  assign s1_fire   = s1_v_r && out_load;
  assign in_tready = !s1_v_r || out_load;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_now_r  <= in_tdata[31:0];
      s1_adc_r  <= in_tdata[47:32];
      s1_busy_r <= in_tdata[48];
    end
  end

  // --------------------------------------------------------------------------
  // Channel state.
  // --------------------------------------------------------------------------
  logic [TIME_W-1:0]    last_sample_time_r, last_sample_time_nxt;
  logic [WAIT_MS_W-1:0] wait_ms_r, wait_ms_nxt;
  logic [SAMPLE_W-1:0]  avg_r, avg_nxt;
  logic [SAMPLE_W-1:0]  last_sent_r, last_sent_nxt;
  logic [TIME_W-1:0]    last_send_time_r, last_send_time_nxt;

  logic [TIME_W-1:0]   dt_send;
  logic [TIME_W-1:0]   dt_sample;
  logic [SAMPLE_W-1:0] diff;
  logic                enabled;
  logic                gap_open;
  logic                max_due;
  logic                delta_due;
  logic                send;
  logic                sample_due;
  logic                sample_en;
  mean_t               mean;
  logic                send_now_nxt;
  logic [SAMPLE_W-1:0] sent_value_nxt;

  // Differences wrap modulo 2^32, so a plain subtract of the timestamps is right
  // across a counter wrap.
  assign dt_send   = s1_now_r - last_send_time_r;
  assign dt_sample = s1_now_r - last_sample_time_r;
  assign diff      = (avg_r >= last_sent_r) ? avg_r - last_sent_r : last_sent_r - avg_r;

  assign enabled    = (update_ms_r != '0);
  // Nothing happens at all, sending or sampling, until the minimum gap has passed.
  assign gap_open   = (min_ms_r == '0) || (dt_send > TIME_W'(min_ms_r));
  assign max_due    = (max_ms_r != '0) && (dt_send >= TIME_W'(max_ms_r));
  assign delta_due  = (delta_r != '0) && (SAMPLE_W'(delta_r) <= diff);
  assign send       = enabled && gap_open && (max_due || delta_due);
  assign sample_due = enabled && gap_open && (dt_sample >= TIME_W'(wait_ms_r));
  assign sample_en  = s1_fire && sample_due;

  arbe_mean #(
    .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
  ) u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample_en (sample_en),
    .sample    (s1_adc_r),
    .result    (mean)
  );

  always_comb begin
    last_sample_time_nxt = last_sample_time_r;
    wait_ms_nxt          = wait_ms_r;
    avg_nxt              = avg_r;
    last_sent_nxt        = last_sent_r;
    last_send_time_nxt   = last_send_time_r;
    send_now_nxt         = 1'b0;
    sent_value_nxt       = '0;

    if (!enabled) begin
      // A disabled channel forgets its reading and what it last sent.
      avg_nxt       = '0;
      last_sent_nxt = '0;
    end else begin
      if (send) begin
        // The offered value is the reading from before this poll's sample.
        // A refused send still restarts the interval, but the last sent value
        // keeps what actually went out.
        send_now_nxt       = 1'b1;
        sent_value_nxt     = avg_r;
        last_send_time_nxt = s1_now_r;
        if (!s1_busy_r) begin
          last_sent_nxt = avg_r;
        end
      end
      if (sample_due) begin
        last_sample_time_nxt = s1_now_r;
        wait_ms_nxt          = WAIT_SHORT_MS;
        if (mean.done) begin
          // A full set: publish its mean and sleep for the update interval.
          avg_nxt     = mean.mean;
          wait_ms_nxt = update_ms_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_time_r <= '0;
      wait_ms_r          <= WAIT_RST_MS;
      avg_r              <= '0;
      last_sent_r        <= '0;
      last_send_time_r   <= '0;
    end else if (s1_fire) begin
      last_sample_time_r <= last_sample_time_nxt;
      wait_ms_r          <= wait_ms_nxt;
      avg_r              <= avg_nxt;
      last_sent_r        <= last_sent_nxt;
      last_send_time_r   <= last_send_time_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  logic                send_now_r;
  logic [SAMPLE_W-1:0] sent_value_r;
  logic [SAMPLE_W-1:0] reading_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      send_now_r   <= send_now_nxt;
      sent_value_r <= sent_value_nxt;
      reading_r    <= avg_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, reading_r, sent_value_r, send_now_r};

`ifndef SYNTHESIS
  a_offer_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !send_now_r |-> sent_value_r == '0)
    else $error("value offered without a send");

  a_state_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(avg_r) && $stable(last_send_time_r) && $stable(last_sent_r))
    else $error("channel state moved without a poll");

  a_disabled_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !enabled |=> avg_r == '0 && last_sent_r == '0 && out_v_r && !send_now_r)
    else $error("disabled channel kept a reading or sent");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_v_r && !out_tready |-> !in_tready)
    else $error("input taken while both stages are full and stalled");
`endif

endmodule

@@ rtl/arbe_mean.sv @@
// ----------------------------------------------------------------------------
// arbe_mean: running sum and truncated mean over a set of raw samples
// Accumulates samples as they are taken and, on the last sample of a set,
// gives the sum divided by the set size through a reciprocal multiplication.
// ----------------------------------------------------------------------------
module arbe_mean #(
  parameter int SAMPLES_PER_AVERAGE = arbe_pkg::SAMPLES_PER_AVERAGE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          sample_en,
  input  logic [arbe_pkg::SAMPLE_W-1:0] sample,
  output arbe_pkg::mean_t               result
);
  import arbe_pkg::*;

  localparam int SLOT_W  = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
  localparam int SUM_W   = SAMPLE_W + $clog2(SAMPLES_PER_AVERAGE);
  // Ceiling reciprocal with three guard bits: exact for every sum below 2^SUM_W
  // since the rounding error times the sum stays under 2^SHIFT.
  localparam int SHIFT   = SUM_W + 3;
  localparam int RECIP_W = SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((longint'(1) << SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SAMPLES_PER_AVERAGE - 1);

  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SUM_W-1:0]  acc_r;
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  logic              last;

  // The accumulator is only read past the first slot, so it needs no reset.
  assign sum  = ((slot_r == '0) ? '0 : acc_r) + SUM_W'(sample);
  assign last = (slot_r == LAST_SLOT);
  assign prod = PROD_W'(sum) * PROD_W'(RECIP);

  assign result.done = sample_en && last;
  assign result.mean = prod[SHIFT +: SAMPLE_W];

  always_comb begin
    slot_nxt = slot_r;
    if (sample_en) begin
      slot_nxt = last ? '0 : slot_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_en) begin
      acc_r <= sum;
    end
  end

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= LAST_SLOT)
    else $error("sample slot beyond the set size");

  a_slot_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    result.done |=> slot_r == '0)
    else $error("sample slot did not restart after a completed set");

  a_slot_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !sample_en |=> $stable(slot_r))
    else $error("sample slot moved without a sample");
`endif

endmodule

@@ test/tb_averaging_report_by_exception.sv @@
// ----------------------------------------------------------------------------
// tb_averaging_report_by_exception: self-checking bench for the averaging
// report-by-exception channel
// A short table of directed polls is followed by random phases, each under its
// own register setting. Every accepted poll is run through a behavioural copy
// of the channel. Every result beat is compared, field by field, with the
// oldest outstanding prediction. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_averaging_report_by_exception;
  import arbe_pkg::*;

  localparam int SETTLE_CYCLES   = 6;     // pipeline is two stages deep
  localparam int DRAIN_CYCLES    = 8;
  localparam int IDLE_LIMIT      = 2000;  // cycles with no beat and no write
  localparam int ITEMS_PER_PHASE = 185;
  localparam int ROWS            = 15;
  localparam int AVG_SET         = SAMPLES_PER_AVERAGE_DEF;
  localparam int MAX_PRINTS      = 40;

  // One poll as it travels on the input stream.
  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] adc_sample;
    logic        link_busy;
  } poll_t;

  // One result beat.
  typedef struct packed {
    logic        send_now;
    logic [15:0] sent_value;
    logic [15:0] reading;
  } report_t;

  // A row of the directed table; the expected report is used only when typed.
  typedef struct {
    poll_t   poll;
    bit      typed;
    report_t want;
  } poll_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;   // now_ms, adc_sample, link_busy
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // send_now, sent_value, reading
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  averaging_report_by_exception dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Behavioural copy of the channel: registers and state as after reset.
  // --------------------------------------------------------------------------
  logic [7:0]  cfg_update_tens = 8'd30;
  logic [7:0]  cfg_delta       = 8'd10;
  logic [15:0] cfg_max_s       = 16'd600;
  logic [7:0]  cfg_min_tens    = 8'd3;

  logic [31:0] last_sample_ms = '0;
  logic [7:0]  wait_tens      = 8'(2 * SAMPLE_WAIT_TENS_DEF);
  logic [15:0] avg_reading    = '0;
  logic [15:0] last_sent      = '0;
  logic [31:0] last_send_ms   = '0;
  logic [15:0] sample_buf [AVG_SET];
  int          sample_slot    = 0;

  report_t     pending_reports [$];
  int          mismatches  = 0;
  int          burst_left  = 0;
  logic [31:0] latest_now  = '0;
  int          idle_cycles = 0;

  // Works out the report for one accepted poll and advances the copied state.
  function automatic void predict_poll(input poll_t p, output report_t r);
    logic [31:0] since_send;
    logic [31:0] since_sample;
    logic [15:0] moved;
    logic [17:0] total;
    bit          max_due;
    bit          delta_due;
    r = '0;
    // A disabled channel forgets both readings and does nothing else.
    if (cfg_update_tens == 8'd0) begin
      avg_reading = '0;
      last_sent   = '0;
      return;
    end
    since_send = p.now_ms - last_send_ms;
    // Inside the minimum gap the poll neither sends nor samples.
    if (cfg_min_tens != 8'd0 && since_send <= 32'(cfg_min_tens) * MS_PER_TEN_S) begin
      r.reading = avg_reading;
      return;
    end
    moved     = (avg_reading >= last_sent) ? avg_reading - last_sent
                                           : last_sent - avg_reading;
    max_due   = cfg_max_s != 16'd0 && since_send >= 32'(cfg_max_s) * MS_PER_S;
    delta_due = cfg_delta != 8'd0 && 32'(moved) >= 32'(cfg_delta) * COUNTS_PER_DELTA;
    if (max_due || delta_due) begin
      r.send_now   = 1'b1;
      r.sent_value = avg_reading;
      // A refused send still restarts the interval but keeps the old value.
      if (!p.link_busy) last_sent = avg_reading;
      last_send_ms = p.now_ms;
    end
    since_sample = p.now_ms - last_sample_ms;
    if (since_sample >= 32'(wait_tens) * MS_PER_TEN_S) begin
      wait_tens                = 8'(SAMPLE_WAIT_TENS_DEF);
      sample_buf[sample_slot]  = p.adc_sample;
      sample_slot++;
      last_sample_ms           = p.now_ms;
      if (sample_slot >= AVG_SET) begin
        sample_slot = 0;
        total       = '0;
        for (int k = 0; k < AVG_SET; k++) total += 18'(sample_buf[k]);
        avg_reading = 16'(total / AVG_SET);
        wait_tens   = cfg_update_tens;
      end
    end
    r.reading = avg_reading;
  endfunction

  // Prints one line per mismatch (up to a cap) and counts every one.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MAX_PRINTS)
      $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Poll sender: bursts of random length separated by random gaps. The poll
  // is predicted at the edge where it is accepted.
  // --------------------------------------------------------------------------
  task automatic drive_poll(input poll_t p, input bit typed, input report_t want);
    report_t pred;
    int      gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, p.link_busy, p.adc_sample, p.now_ms};
    do @(posedge clk); while (!in_tready);
    predict_poll(p, pred);
    latest_now = p.now_ms;
    pending_reports.push_back(typed ? want : pred);
  endtask

  // One register write; the copy follows at the same edge.
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_UPDATE_INTERVAL: cfg_update_tens = data[7:0];
      REG_SEND_DELTA:      cfg_delta       = data[7:0];
      REG_SEND_MAX:        cfg_max_s       = data;
      REG_SEND_MIN:        cfg_min_tens    = data[7:0];
      default: ;
    endcase
  endtask

  // Waits for the channel to drain, writes all four registers, then sends a
  // phase of random polls. Timestamps mostly move forwards by steps scaled to
  // the intervals; some land exactly on an interval boundary, some jump
  // anywhere in the 32-bit range so that the wrapping differences are used.
  task automatic run_phase(input logic [15:0] upd, input logic [15:0] dlt,
                           input logic [15:0] mx, input logic [15:0] mn);
    poll_t       p;
    int          tens;
    int          step_ms;
    int          pick;
    int          span;
    int          level;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_UPDATE_INTERVAL, upd);
    write_reg(REG_SEND_DELTA, dlt);
    write_reg(REG_SEND_MAX, mx);
    write_reg(REG_SEND_MIN, mn);
    cfg_we <= 1'b0;
    tens = (cfg_update_tens > cfg_min_tens) ? int'(cfg_update_tens) : int'(cfg_min_tens);
    if (tens == 0) tens = 1;
    step_ms = tens * 12000;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6)
        p.now_ms = $urandom;
      else if (pick < 14)
        p.now_ms = last_send_ms + 32'(cfg_min_tens) * MS_PER_TEN_S + $urandom_range(0, 1);
      else if (pick < 22)
        p.now_ms = last_sample_ms + 32'(wait_tens) * MS_PER_TEN_S - $urandom_range(0, 1);
      else if (pick < 30)
        p.now_ms = last_send_ms + 32'(cfg_max_s) * MS_PER_S - $urandom_range(0, 1);
      else if (pick < 40)
        p.now_ms = latest_now + $urandom_range(0, 20);
      else
        p.now_ms = latest_now + $urandom_range(0, step_ms);
      // Samples near the current reading keep the change test close to its
      // threshold; the rest are extremes or anything at all.
      pick = $urandom_range(0, 9);
      if (pick == 0)
        p.adc_sample = 16'h0000;
      else if (pick == 1)
        p.adc_sample = 16'hFFFF;
      else if (pick < 6) begin
        span  = int'(cfg_delta) * 12 + 4;
        level = int'(avg_reading) + int'($urandom_range(0, 2 * span)) - span;
        if (level < 0) level = 0;
        if (level > 65535) level = 65535;
        p.adc_sample = 16'(level);
      end else
        p.adc_sample = 16'($urandom);
      p.link_busy = ($urandom_range(0, 2) == 0);
      drive_poll(p, 1'b0, '0);
    end
    in_tvalid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result receiver: the ready pattern rotates and is redrawn as the tick wraps,
  // sometimes as all ones so that long stretches without stalls occur.
  // --------------------------------------------------------------------------
  logic [15:0] stall_pat  = 16'hFFFF;
  logic [5:0]  stall_tick = '0;

  always @(posedge clk) begin
    if (stall_tick == 6'd0)
      stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    else
      stall_pat <= {stall_pat[14:0], stall_pat[15]};
    stall_tick <= stall_tick + 6'd1;
    out_tready <= stall_pat[15];
  end

  // Every result beat is checked against the oldest outstanding prediction.
  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.send_now   = out_tdata[0];
      got.sent_value = out_tdata[16:1];
      got.reading    = out_tdata[32:17];
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected beat", 32'(got), 32'd0);
      end else begin
        want = pending_reports.pop_front();
        if (got.send_now !== want.send_now)
          report_mismatch("send_now", 32'(got.send_now), 32'(want.send_now));
        if (got.sent_value !== want.sent_value)
          report_mismatch("sent_value", 32'(got.sent_value), 32'(want.sent_value));
        if (got.reading !== want.reading)
          report_mismatch("reading", 32'(got.reading), 32'(want.reading));
      end
    end
  end

  // Watchdog: a run that stops moving is a failure.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence.
  // --------------------------------------------------------------------------
  function automatic poll_row_t mk_row(input logic [31:0] t, input logic [15:0] a,
                                       input logic b, input bit typed, input logic s,
                                       input logic [15:0] v, input logic [15:0] r);
    poll_row_t row;
    row.poll  = '{now_ms: t, adc_sample: a, link_busy: b};
    row.typed = typed;
    row.want  = '{send_now: s, sent_value: v, reading: r};
    return row;
  endfunction

  initial begin
    poll_row_t   rows [ROWS];
    logic [15:0] r_upd;
    logic [15:0] r_dlt;
    logic [15:0] r_max;
    logic [15:0] r_min;

    // Directed table, run under the reset values of the registers. The first
    // eleven rows walk the channel from reset: a poll inside the minimum gap,
    // a full set of top-scale samples, a send refused by a busy bus, the
    // minimum gap exactly reached and just passed, and a set with a mean of one.
    // Later rows reach the forced send and wrapping timestamps.
    rows = '{
      mk_row(32'd0,      16'h1234, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000),
      mk_row(32'd30001,  16'hFFFF, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000),
      mk_row(32'd40001,  16'hFFFF, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000),
      mk_row(32'd50001,  16'hFFFF, 1'b0, 1'b1, 1'b0, 16'h0000, 16'hFFFF),
      mk_row(32'd50002,  16'h0000, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF),
      mk_row(32'd80002,  16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000, 16'hFFFF),
      mk_row(32'd80003,  16'h0000, 1'b0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF),
      mk_row(32'd350001, 16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000, 16'hFFFF),
      mk_row(32'd360001, 16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000, 16'hFFFF),
      mk_row(32'd370001, 16'h0003, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0001),
      mk_row(32'd370002, 16'h0000, 1'b0, 1'b1, 1'b1, 16'h0001, 16'h0001),
      mk_row(32'd970002, 16'h8000, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000),
      mk_row(32'hFFFFFFFF, 16'h7FFF, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000),
      mk_row(32'd30000,  16'h5555, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000),
      mk_row(32'd30001,  16'hAAAA, 1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000)
    };

    // Synchronous reset, held from the start and never asserted again.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < ROWS; i++) drive_poll(rows[i].poll, rows[i].typed, rows[i].want);
    in_tvalid <= 1'b0;

    // Fixed settings: fast sends, channel disabled, every register at its top
    // value, change and forced sends both off, a middle setting, and a
    // one-second forced send with the largest change threshold.
    run_phase(16'd1,   16'd1,   16'd5,     16'd0);
    run_phase(16'd0,   16'd10,  16'd600,   16'd3);
    run_phase(16'd255, 16'd255, 16'd65535, 16'd255);
    run_phase(16'd1,   16'd0,   16'd0,     16'd0);
    run_phase(16'd2,   16'd3,   16'd20,    16'd1);
    run_phase(16'd1,   16'd255, 16'd1,     16'd0);

    // Random settings; the upper bits of the narrow registers carry noise.
    for (int k = 0; k < 4; k++) begin
      r_upd = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3));
      r_dlt = 16'($urandom);
      r_max = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
      r_min = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
      run_phase(r_upd, r_dlt, r_max, r_min);
    end

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
